// ===== src/lspf_pkg.sv =====
// lspf_pkg: shared types, constants and helper functions of the plane fit unit
// no dependencies; imported by every module of the block

package lspf_pkg;

   localparam int COORD_W    = 16;
   localparam int FRAC_BITS  = 16;
   localparam int MAX_POINTS = 4096;
   localparam int CNT_W      = 13;
   localparam int SUM1_W     = 29;
   localparam int SUM2_W     = 44;
   localparam int DET_W      = 120;
   localparam int COEF_W     = 48;
   localparam int ENT_IDX_W  = 4;
   localparam int STEP_W     = 4;
   localparam int NUM_STEPS  = 9;
   localparam int COL_W      = 2;

   typedef enum logic [1:0] {
      FIT_OK        = 2'd0,
      FIT_SINGULAR  = 2'd1,
      FIT_SATURATED = 2'd2,
      FIT_OVERFLOW  = 2'd3
   } fit_status_type;

   typedef enum logic {
      ACC_IDLE,
      ACC_MUL
   } acc_state_type;

   typedef enum logic [2:0] {
      SLV_IDLE,
      SLV_MAC_GO,
      SLV_MAC_RUN,
      SLV_NEXT,
      SLV_DIV_GO,
      SLV_DIV_RUN,
      SLV_FINISH
   } solve_state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] pt_x;
      logic signed [COORD_W-1:0] pt_y;
      logic signed [COORD_W-1:0] pt_z;
      logic                      last_point;
   } req_word_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [COEF_W-1:0] coef_c;
      logic [1:0]               fit_status;
      logic [CNT_W-1:0]         used_points;
   } rsp_word_type;

   typedef struct packed {
      logic signed [SUM2_W-1:0] xx;
      logic signed [SUM2_W-1:0] xy;
      logic signed [SUM2_W-1:0] yy;
      logic signed [SUM2_W-1:0] xz;
      logic signed [SUM2_W-1:0] yz;
      logic signed [SUM1_W-1:0] x;
      logic signed [SUM1_W-1:0] y;
      logic signed [SUM1_W-1:0] z;
      logic [CNT_W-1:0]         n;
   } sums_type;

   typedef struct packed {
      logic                 to_det;
      logic                 clr;
      logic                 neg;
      logic [ENT_IDX_W-1:0] a_idx;
      logic [ENT_IDX_W-1:0] b_idx;
   } mac_cmd_type;

   // cofactor expansion along the first row, one multiply-accumulate per step
   function automatic mac_cmd_type mac_op(input logic [STEP_W-1:0] step);
      mac_cmd_type c;
      c = '{1'b0, 1'b0, 1'b0, 4'd0, 4'd0};
      case (step)
         4'd0: c = '{1'b0, 1'b1, 1'b0, 4'd4, 4'd8};
         4'd1: c = '{1'b0, 1'b0, 1'b1, 4'd5, 4'd7};
         4'd2: c = '{1'b1, 1'b1, 1'b0, 4'd0, 4'd0};
         4'd3: c = '{1'b0, 1'b1, 1'b0, 4'd3, 4'd8};
         4'd4: c = '{1'b0, 1'b0, 1'b1, 4'd5, 4'd6};
         4'd5: c = '{1'b1, 1'b0, 1'b1, 4'd1, 4'd0};
         4'd6: c = '{1'b0, 1'b1, 1'b0, 4'd3, 4'd7};
         4'd7: c = '{1'b0, 1'b0, 1'b1, 4'd4, 4'd6};
         4'd8: c = '{1'b1, 1'b0, 1'b0, 4'd2, 4'd0};
         default: c = '{1'b0, 1'b0, 1'b0, 4'd0, 4'd0};
      endcase
      return c;
   endfunction

   // matrix entry; col 1..3 swaps that column for the right-hand side
   function automatic logic signed [SUM2_W-1:0] mat_entry(input sums_type s,
                                                        input logic [ENT_IDX_W-1:0] idx,
                                                        input logic [COL_W-1:0] col);
      logic signed [SUM2_W-1:0] xs;
      logic signed [SUM2_W-1:0] ys;
      logic signed [SUM2_W-1:0] zs;
      logic signed [SUM2_W-1:0] ns;
      logic signed [SUM2_W-1:0] v;
      logic signed [SUM2_W-1:0] rhs;
      logic [COL_W-1:0]         c_of;
      xs = {{(SUM2_W-SUM1_W){s.x[SUM1_W-1]}}, s.x};
      ys = {{(SUM2_W-SUM1_W){s.y[SUM1_W-1]}}, s.y};
      zs = {{(SUM2_W-SUM1_W){s.z[SUM1_W-1]}}, s.z};
      ns = {{(SUM2_W-CNT_W){1'b0}}, s.n};
      v = '0;
      rhs = '0;
      c_of = '0;
      case (idx)
         4'd0: begin v = s.xx; rhs = s.xz; c_of = 2'd0; end
         4'd1: begin v = s.xy; rhs = s.xz; c_of = 2'd1; end
         4'd2: begin v = xs;   rhs = s.xz; c_of = 2'd2; end
         4'd3: begin v = s.xy; rhs = s.yz; c_of = 2'd0; end
         4'd4: begin v = s.yy; rhs = s.yz; c_of = 2'd1; end
         4'd5: begin v = ys;   rhs = s.yz; c_of = 2'd2; end
         4'd6: begin v = xs;   rhs = zs;   c_of = 2'd0; end
         4'd7: begin v = ys;   rhs = zs;   c_of = 2'd1; end
         4'd8: begin v = ns;   rhs = zs;   c_of = 2'd2; end
         default: begin v = '0; rhs = '0; c_of = 2'd3; end
      endcase
      if (col != 2'd0 && c_of == col - 2'd1) begin
         v = rhs;
      end
      return v;
   endfunction

endpackage

// ===== src/lspf_accum.v.sv =====
// lspf_accum: normal-equation sums, one shared 16x16 multiplier over five steps
// depends on lspf_pkg

module lspf_accum import lspf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_word_type word,
   input  logic         clear,
   output sums_type     sums,
   output logic         overflowed,
   output logic         busy,
   output logic         solve_req
);

   localparam int LAST_STEP = 5;

   acc_state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [COORD_W-1:0] ma, mb;
   logic last_ff, last_in;
   logic signed [2*COORD_W-1:0] prod_ff, prod_in;
   logic signed [SUM2_W-1:0] prod_ext;
   sums_type sums_ff, sums_in;
   logic ovf_ff, ovf_in;
   logic req_ff, req_in;
   logic room;

   assign room = (sums_ff.n < CNT_W'(MAX_POINTS));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ACC_IDLE: begin
            if (start && room) state_in = ACC_MUL;
         end
         ACC_MUL: begin
            if (step_ff == 3'(LAST_STEP)) state_in = ACC_IDLE;
         end
         default: state_in = ACC_IDLE;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      last_in = last_ff;
      sums_in = sums_ff;
      ovf_in = ovf_ff;
      req_in = 1'b0;
      case (step_ff)
         3'd0: begin ma = x_ff; mb = x_ff; end
         3'd1: begin ma = x_ff; mb = y_ff; end
         3'd2: begin ma = y_ff; mb = y_ff; end
         3'd3: begin ma = x_ff; mb = z_ff; end
         3'd4: begin ma = y_ff; mb = z_ff; end
         default: begin ma = x_ff; mb = x_ff; end
      endcase
      prod_in = ma * mb;
      prod_ext = {{(SUM2_W-2*COORD_W){prod_ff[2*COORD_W-1]}}, prod_ff};
      case (state_ff)
         ACC_IDLE: begin
            if (start) begin
               x_in = word.pt_x;
               y_in = word.pt_y;
               z_in = word.pt_z;
               last_in = word.last_point;
               step_in = '0;
               if (room) begin
                  sums_in.x = sums_ff.x + {{(SUM1_W-COORD_W){word.pt_x[COORD_W-1]}}, word.pt_x};
                  sums_in.y = sums_ff.y + {{(SUM1_W-COORD_W){word.pt_y[COORD_W-1]}}, word.pt_y};
                  sums_in.z = sums_ff.z + {{(SUM1_W-COORD_W){word.pt_z[COORD_W-1]}}, word.pt_z};
                  sums_in.n = sums_ff.n + 1'b1;
               end else begin
                  ovf_in = 1'b1;
                  req_in = word.last_point;
               end
            end
         end
         ACC_MUL: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               3'd1: sums_in.xx = sums_ff.xx + prod_ext;
               3'd2: sums_in.xy = sums_ff.xy + prod_ext;
               3'd3: sums_in.yy = sums_ff.yy + prod_ext;
               3'd4: sums_in.xz = sums_ff.xz + prod_ext;
               3'd5: begin
                  sums_in.yz = sums_ff.yz + prod_ext;
                  req_in = last_ff;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      if (clear) begin
         sums_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ACC_IDLE;
         sums_ff <= '0;
         ovf_ff <= 1'b0;
         req_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sums_ff <= sums_in;
         ovf_ff <= ovf_in;
         req_ff <= req_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      last_ff <= last_in;
      prod_ff <= prod_in;
   end

   assign sums = sums_ff;
   assign overflowed = ovf_ff;
   assign busy = (state_ff != ACC_IDLE) || req_ff;
   assign solve_req = req_ff;

endmodule

// ===== src/lspf_mac.sv =====
// lspf_mac: shift-add multiply-accumulate unit, one multiplier bit per cycle
// depends on lspf_pkg; holds the cofactor and determinant accumulators

module lspf_mac import lspf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  mac_cmd_type              cmd,
   input  logic signed [DET_W-1:0]  mcand,
   input  logic signed [SUM2_W-1:0] mplier,
   output logic                     done,
   output logic signed [DET_W-1:0]  cof,
   output logic signed [DET_W-1:0]  det
);

   localparam int CW = $clog2(SUM2_W);

   logic run_ff, run_in;
   logic done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic to_det_ff, to_det_in;
   logic [DET_W-1:0] p_ff, p_in, cof_ff, cof_in, det_ff, det_in;
   logic [DET_W-1:0] dst, addend, total;
   logic [SUM2_W-1:0] q_ff, q_in;
   logic last_bit;

   always_comb begin
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      to_det_in = to_det_ff;
      p_in = p_ff;
      q_in = q_ff;
      cof_in = cof_ff;
      det_in = det_ff;
      last_bit = (cnt_ff == CW'(SUM2_W-1));
      dst = to_det_ff ? det_ff : cof_ff;
      // sign bit of the multiplier carries negative weight
      addend = last_bit ? ~p_ff : p_ff;
      total = dst + addend + {{(DET_W-1){1'b0}}, last_bit};
      if (go) begin
         run_in = 1'b1;
         cnt_in = '0;
         to_det_in = cmd.to_det;
         p_in = cmd.neg ? -mcand : mcand;
         q_in = mplier;
         if (cmd.clr) begin
            if (cmd.to_det) det_in = '0;
            else cof_in = '0;
         end
      end else if (run_ff) begin
         if (q_ff[0]) begin
            if (to_det_ff) det_in = total;
            else cof_in = total;
         end
         p_in = p_ff << 1;
         q_in = q_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (last_bit) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      to_det_ff <= to_det_in;
      p_ff <= p_in;
      q_ff <= q_in;
      cof_ff <= cof_in;
      det_ff <= det_in;
   end

   assign done = done_ff;
   assign cof = cof_ff;
   assign det = det_ff;

   a_go_idle: assert property (@(posedge clock) disable iff (reset) go |-> !run_ff)
      else $error("mac started while running");
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff))
      else $error("mac done without a run");
   a_run_holds: assert property (@(posedge clock) disable iff (reset)
      run_ff && !last_bit |=> run_ff)
      else $error("mac run ended early");

endmodule

// ===== src/lspf_div.sv =====
// lspf_div: restoring divider for (num * 2^FRAC_BITS) / den, one quotient bit per cycle
// depends on lspf_pkg; truncates toward zero and saturates to the coefficient width

module lspf_div import lspf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  logic signed [DET_W-1:0]  num,
   input  logic signed [DET_W-1:0]  den,
   output logic                     done,
   output logic signed [COEF_W-1:0] quot,
   output logic                     sat
);

   localparam int NUM_W = DET_W + FRAC_BITS;
   localparam int CW    = $clog2(NUM_W + 1);
   localparam int Q_W   = COEF_W + 1;

   logic run_ff, run_in;
   logic done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in;
   logic big_ff, big_in;
   logic [NUM_W-1:0] n_ff, n_in;
   logic [DET_W-1:0] d_ff, d_in, rem_ff, rem_in;
   logic [Q_W-1:0] q_ff, q_in;
   logic [DET_W-1:0] abs_num, abs_den;
   logic [DET_W:0] r_sh;
   logic [DET_W+1:0] diff;
   logic ge;
   logic over;
   logic [COEF_W-1:0] mag;

   always_comb begin
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      big_in = big_ff;
      n_in = n_ff;
      d_in = d_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      abs_num = num[DET_W-1] ? -num : num;
      abs_den = den[DET_W-1] ? -den : den;
      r_sh = {rem_ff, n_ff[NUM_W-1]};
      diff = {1'b0, r_sh} - {2'b00, d_ff};
      ge = !diff[DET_W+1];
      if (go) begin
         run_in = 1'b1;
         cnt_in = '0;
         neg_in = num[DET_W-1] ^ den[DET_W-1];
         big_in = 1'b0;
         n_in = {abs_num, {FRAC_BITS{1'b0}}};
         d_in = abs_den;
         rem_in = '0;
         q_in = '0;
      end else if (run_ff) begin
         rem_in = ge ? diff[DET_W-1:0] : r_sh[DET_W-1:0];
         n_in = n_ff << 1;
         big_in = big_ff | q_ff[Q_W-1];
         q_in = {q_ff[Q_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NUM_W-1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      over = big_ff | q_ff[Q_W-1];
      mag = q_ff[COEF_W-1:0];
      if (neg_ff) begin
         sat = over | (mag[COEF_W-1] & (|mag[COEF_W-2:0]));
         quot = sat ? {1'b1, {(COEF_W-1){1'b0}}} : -mag;
      end else begin
         sat = over | mag[COEF_W-1];
         quot = sat ? {1'b0, {(COEF_W-1){1'b1}}} : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      big_ff <= big_in;
      n_ff <= n_in;
      d_ff <= d_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
   end

   assign done = done_ff;

endmodule

// ===== src/lspf_solve.sv =====
// lspf_solve: Cramer solve; main det, then per column a det and a division
// depends on lspf_pkg, lspf_mac and lspf_div

module lspf_solve import lspf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  sums_type     sums,
   input  logic         overflowed,
   output logic         busy,
   output logic         clear_sums,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   localparam logic [COL_W-1:0] LAST_COL = 2'd3;

   solve_state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic signed [DET_W-1:0] dd_ff, dd_in;
   logic signed [COEF_W-1:0] ca_ff, ca_in, cb_ff, cb_in, cc_ff, cc_in;
   logic sat_ff, sat_in, sing_ff, sing_in;
   logic valid_ff, valid_in;
   rsp_word_type word_ff, word_in;

   mac_cmd_type cmd;
   logic signed [SUM2_W-1:0] ent_a, ent_b;
   logic signed [DET_W-1:0] mcand;
   logic signed [SUM2_W-1:0] mplier;
   logic mac_go, mac_done, div_go, div_done, div_sat;
   logic signed [DET_W-1:0] cof, det;
   logic signed [COEF_W-1:0] quot;
   logic last_step, det_zero;

   assign cmd = mac_op(step_ff);
   assign ent_a = mat_entry(sums, cmd.a_idx, col_ff);
   assign ent_b = mat_entry(sums, cmd.b_idx, col_ff);
   assign mcand = cmd.to_det ? cof : {{(DET_W-SUM2_W){ent_a[SUM2_W-1]}}, ent_a};
   assign mplier = cmd.to_det ? ent_a : ent_b;
   assign last_step = (step_ff == STEP_W'(NUM_STEPS-1));
   assign det_zero = (det == '0);

   lspf_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .go     (mac_go),
      .cmd    (cmd),
      .mcand  (mcand),
      .mplier (mplier),
      .done   (mac_done),
      .cof    (cof),
      .det    (det)
   );

   lspf_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (det),
      .den   (dd_ff),
      .done  (div_done),
      .quot  (quot),
      .sat   (div_sat)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SLV_IDLE:    if (go) state_in = SLV_MAC_GO;
         SLV_MAC_GO:  state_in = SLV_MAC_RUN;
         SLV_MAC_RUN: if (mac_done) state_in = SLV_NEXT;
         SLV_NEXT: begin
            if (!last_step) state_in = SLV_MAC_GO;
            else if (col_ff != 2'd0) state_in = SLV_DIV_GO;
            else if (det_zero) state_in = SLV_FINISH;
            else state_in = SLV_MAC_GO;
         end
         SLV_DIV_GO:  state_in = SLV_DIV_RUN;
         SLV_DIV_RUN: begin
            if (div_done) state_in = (col_ff == LAST_COL) ? SLV_FINISH : SLV_MAC_GO;
         end
         SLV_FINISH:  state_in = SLV_IDLE;
         default:     state_in = SLV_IDLE;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      col_in = col_ff;
      dd_in = dd_ff;
      ca_in = ca_ff;
      cb_in = cb_ff;
      cc_in = cc_ff;
      sat_in = sat_ff;
      sing_in = sing_ff;
      valid_in = 1'b0;
      word_in = word_ff;
      mac_go = 1'b0;
      div_go = 1'b0;
      clear_sums = 1'b0;
      case (state_ff)
         SLV_IDLE: begin
            if (go) begin
               step_in = '0;
               col_in = '0;
               sat_in = 1'b0;
               sing_in = 1'b0;
            end
         end
         SLV_MAC_GO: mac_go = 1'b1;
         SLV_NEXT: begin
            if (!last_step) begin
               step_in = step_ff + 1'b1;
            end else if (col_ff == 2'd0) begin
               if (det_zero) begin
                  sing_in = 1'b1;
               end else begin
                  dd_in = det;
                  col_in = 2'd1;
                  step_in = '0;
               end
            end
         end
         SLV_DIV_GO: div_go = 1'b1;
         SLV_DIV_RUN: begin
            if (div_done) begin
               case (col_ff)
                  2'd1: ca_in = quot;
                  2'd2: cb_in = quot;
                  default: cc_in = quot;
               endcase
               sat_in = sat_ff | div_sat;
               col_in = col_ff + 1'b1;
               step_in = '0;
            end
         end
         SLV_FINISH: begin
            clear_sums = 1'b1;
            valid_in = 1'b1;
            word_in.used_points = sums.n;
            if (sing_ff) begin
               word_in.coef_a = '0;
               word_in.coef_b = '0;
               word_in.coef_c = '0;
               word_in.fit_status = FIT_SINGULAR;
            end else begin
               word_in.coef_a = ca_ff;
               word_in.coef_b = cb_ff;
               word_in.coef_c = cc_ff;
               if (overflowed) word_in.fit_status = FIT_OVERFLOW;
               else if (sat_ff) word_in.fit_status = FIT_SATURATED;
               else word_in.fit_status = FIT_OK;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SLV_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      col_ff <= col_in;
      dd_ff <= dd_in;
      ca_ff <= ca_in;
      cb_ff <= cb_in;
      cc_ff <= cc_in;
      sat_ff <= sat_in;
      sing_ff <= sing_in;
      word_ff <= word_in;
   end

   assign busy = (state_ff != SLV_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_word = word_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      valid_ff |=> !valid_ff)
      else $error("result strobe longer than one cycle");
   a_go_when_idle: assert property (@(posedge clock) disable iff (reset)
      go |-> state_ff == SLV_IDLE)
      else $error("solve requested while busy");
   a_mac_done_state: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == SLV_MAC_RUN)
      else $error("mac finished outside its wait state");

endmodule

// ===== src/least_squares_plane_fit_unit.sv =====
// least_squares_plane_fit_unit: top level, point accumulation and Cramer solve
// a point holds the block while the shared multiplier forms its five products;
// a point past capacity skips the products and sets the overflow flag; a final point
// strobes its word once 36 serial 44-bit multiply-accumulates and three divisions
// are done, or once 9 multiply-accumulates are done when singular
// points are taken only while idle; results are strobed for one cycle, no stall
// reset clears the sums, the count and the overflow flag; none of this needs a sweep

module least_squares_plane_fit_unit import lspf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   logic accept;
   logic acc_busy, slv_busy;
   logic solve_req, clear_sums, overflowed;
   sums_type sums;

   assign busy = acc_busy | slv_busy;
   assign accept = start & !busy;

   lspf_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .word       (req_word),
      .clear      (clear_sums),
      .sums       (sums),
      .overflowed (overflowed),
      .busy       (acc_busy),
      .solve_req  (solve_req)
   );

   lspf_solve u_solve (
      .clock      (clock),
      .reset      (reset),
      .go         (solve_req),
      .sums       (sums),
      .overflowed (overflowed),
      .busy       (slv_busy),
      .clear_sums (clear_sums),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word)
   );

endmodule

// ===== tb/sv/testbench.sv =====
// testbench: directed and random point sets for least_squares_plane_fit_unit
// depends on lspf_pkg and the unit; predicts each fit with wide integer Cramer solve
`timescale 1ns / 100ps

class plane_fit_scoreboard;
   typedef logic signed [255:0] wide_t;

   longint sxx, sxy, syy, sxz, syz, sx, sy, sz;
   int unsigned npts;
   bit overflowed;
   lspf_pkg::rsp_word_type fit_queue[$];
   int errors;

   function new();
      clear_sums();
      errors = 0;
   endfunction

   function void clear_sums();
      sxx = 0; sxy = 0; syy = 0; sxz = 0; syz = 0;
      sx = 0; sy = 0; sz = 0;
      npts = 0;
      overflowed = 0;
   endfunction

   function wide_t det3(input wide_t m[9]);
      return m[0] * (m[4] * m[8] - m[5] * m[7]) - m[1] * (m[3] * m[8] - m[5] * m[6])
         + m[2] * (m[3] * m[7] - m[4] * m[6]);
   endfunction

   function logic [47:0] fixed_quot(input wide_t num, input wide_t den, inout bit sat);
      logic [255:0] n;
      logic [255:0] d;
      logic [255:0] q;
      bit neg;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = (n << lspf_pkg::FRAC_BITS) / d;
      if (neg) begin
         if (q > 256'h8000_0000_0000) begin
            sat = 1;
            q = 256'h8000_0000_0000;
         end
         return 48'(-q);
      end
      if (q > 256'h7FFF_FFFF_FFFF) begin
         sat = 1;
         q = 256'h7FFF_FFFF_FFFF;
      end
      return q[47:0];
   endfunction

   function void note_point(input lspf_pkg::req_word_type w);
      longint x, y, z;
      wide_t a[9];
      wide_t m[9];
      wide_t rhs[3];
      wide_t dd;
      logic [47:0] coef[3];
      bit sat;
      lspf_pkg::rsp_word_type r;
      x = w.pt_x; y = w.pt_y; z = w.pt_z;
      if (npts < lspf_pkg::MAX_POINTS) begin
         sxx += x * x; sxy += x * y; syy += y * y;
         sxz += x * z; syz += y * z;
         sx += x; sy += y; sz += z;
         npts++;
      end else begin
         overflowed = 1;
      end
      if (!w.last_point) return;
      a = '{sxx, sxy, sx, sxy, syy, sy, sx, sy, longint'(npts)};
      rhs = '{sxz, syz, sz};
      dd = det3(a);
      sat = 0;
      coef = '{48'd0, 48'd0, 48'd0};
      r.fit_status = lspf_pkg::FIT_OK;
      if (dd == 0) begin
         r.fit_status = lspf_pkg::FIT_SINGULAR;
      end else begin
         for (int k = 0; k < 3; k++) begin
            m = a;
            m[k] = rhs[0]; m[3 + k] = rhs[1]; m[6 + k] = rhs[2];
            coef[k] = fixed_quot(det3(m), dd, sat);
         end
         if (overflowed) r.fit_status = lspf_pkg::FIT_OVERFLOW;
         else if (sat) r.fit_status = lspf_pkg::FIT_SATURATED;
      end
      r.coef_a = coef[0];
      r.coef_b = coef[1];
      r.coef_c = coef[2];
      r.used_points = npts[12:0];
      fit_queue.push_back(r);
      clear_sums();
   endfunction

   function void check_fit(input lspf_pkg::rsp_word_type got);
      lspf_pkg::rsp_word_type exp_w;
      if (fit_queue.size() == 0) begin
         $display("%0t unexpected word, got %h", $realtime, got);
         errors++;
         return;
      end
      exp_w = fit_queue.pop_front();
      if (got.coef_a !== exp_w.coef_a)
         $display("%0t coef_a exp %h got %h", $realtime, exp_w.coef_a, got.coef_a);
      if (got.coef_b !== exp_w.coef_b)
         $display("%0t coef_b exp %h got %h", $realtime, exp_w.coef_b, got.coef_b);
      if (got.coef_c !== exp_w.coef_c)
         $display("%0t coef_c exp %h got %h", $realtime, exp_w.coef_c, got.coef_c);
      if (got.fit_status !== exp_w.fit_status)
         $display("%0t fit_status exp %0d got %0d", $realtime, exp_w.fit_status,
                  got.fit_status);
      if (got.used_points !== exp_w.used_points)
         $display("%0t used_points exp %0d got %0d", $realtime, exp_w.used_points,
                  got.used_points);
      if (got !== exp_w) errors++;
   endfunction
endclass

module testbench;
   import lspf_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_valid;
   rsp_word_type rsp_word;

   plane_fit_scoreboard fits = new();
   int sent = 0;

   always #1 clock = ~clock;

   least_squares_plane_fit_unit u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_word(rsp_word)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid) fits.check_fit(rsp_word);
   end

   function automatic int gap_len();
      int p;
      p = $urandom_range(99);
      if (p < 60) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(3))
         0: return 16'($signed($urandom_range(40)) - 20);
         1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_point(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic last, input bit gaps);
      req_word_type w;
      int g;
      w.pt_x = x; w.pt_y = y; w.pt_z = z; w.last_point = last;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      fits.note_point(w);
      sent++;
   endtask

   task automatic send_set(input int n, input int shape);
      logic [15:0] x, y, z, dx, dy;
      dx = 16'($urandom_range(1, 5));
      dy = 16'($urandom_range(0, 5));
      for (int i = 0; i < n; i++) begin
         x = rand_coord(); y = rand_coord(); z = rand_coord();
         if (shape == 1) begin
            x = 16'(i) * dx;
            y = 16'(i) * dy;
         end else if (shape == 2) begin
            x = 16'(i) * dx + ((i == n - 1) ? 16'd1 : 16'd0);
            y = 16'(i) * dx;
            z = $urandom_range(1) ? 16'h7FFF : 16'h8000;
         end
         send_point(x, y, z, i == n - 1, 1);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // extremes and a plain plane
      send_point(16'h8000, 16'h8000, 16'h7FFF, 0, 0);
      send_point(16'h7FFF, 16'h8000, 16'h8000, 0, 0);
      send_point(16'h8000, 16'h7FFF, 16'h8000, 0, 0);
      send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 0);
      send_point(16'd0, 16'd0, 16'd5, 0, 0);
      send_point(16'd1, 16'd0, 16'd7, 0, 0);
      send_point(16'd0, 16'd1, 16'hFFFD, 1, 0);
      // single point, two points, collinear
      send_point(16'd3, 16'd4, 16'd5, 1, 0);
      send_point(16'd3, 16'd4, 16'd5, 0, 0);
      send_point(16'hFFFF, 16'd2, 16'd9, 1, 0);
      send_set(6, 1);
      // nearly collinear with large z, may clamp
      send_set(8, 2);
      // more points than the unit holds
      for (int i = 0; i < MAX_POINTS + 3; i++)
         send_point(rand_coord(), rand_coord(), rand_coord(), i == MAX_POINTS + 2, 0);
      while (sent < MAX_POINTS + 700) begin
         case ($urandom_range(19))
            0: send_set($urandom_range(1, 2), 0);
            1, 2: send_set($urandom_range(3, 10), 1);
            3, 4: send_set($urandom_range(3, 10), 2);
            default: send_set($urandom_range(3, 14), 0);
         endcase
      end
      start <= 1'b0;
      while (fits.fit_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fits.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule

// ===== sim.f =====
src/lspf_pkg.sv
src/lspf_accum.v.sv
src/lspf_mac.sv
src/lspf_div.sv
src/lspf_solve.sv
src/least_squares_plane_fit_unit.sv
tb/sv/testbench.sv
